FILE: src/sha_pkg.sv
// Shared constants, types and round functions of the SHA-256 engine.
// Depends on nothing; used by every module under src.
package sha_pkg;

    localparam int WordWidth = 32;
    localparam int Rounds    = 64;

    typedef logic [WordWidth-1:0] word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;      // write the input byte into the current slot
        logic pad_byte;    // write a padding byte (0x80 or zero) into the slot
        logic pad_first;   // the padding byte is 0x80
        logic put_length;  // write the bit length into words 14 and 15
        logic load_vars;   // copy chain hash into the working variables
        logic round;       // run one compression round
        logic fold;        // add working variables into the chain hash
        logic restart;     // restore initial values and clear the count
        logic shift_out;   // rotate chain hash by one word for output
    } sha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] byte_slot;
        logic [5:0] round_count;
    } sha_stat_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t r;
        r = '0;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = '0;
        endcase
        return r;
    endfunction

    localparam word_t RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage

FILE: src/sha_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing.
interface sha_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/sha_datapath.sv
// Datapath of the SHA-256 engine: block window, working variables,
// chain hash and bit count. Depends on sha_pkg.
module sha_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha_pkg::sha_cmd_t     cmd,
    input  logic [7:0]            message_byte,
    output sha_pkg::sha_stat_t    stat,
    output sha_pkg::word_t        head_word
);

    sha_pkg::word_t win_reg  [16];
    sha_pkg::word_t vars_reg [8];
    sha_pkg::word_t hash_reg [8];
    logic [63:0]    count_reg;
    logic [5:0]     slot_reg;
    logic [5:0]     round_reg;

    logic [7:0]     put_val;
    logic [3:0]     put_w;
    logic [1:0]     put_b;
    sha_pkg::word_t w15, w2, sched_w, rnd_w, t1, t2, s0, s1, ch, mj;

    // Byte to be written this cycle.
    always_comb
    begin
        put_val = cmd.absorb ? message_byte : (cmd.pad_first ? 8'h80 : 8'h00);
        put_w   = slot_reg[5:2];
        put_b   = slot_reg[1:0];
    end

    // Message schedule word and round arithmetic.
    always_comb
    begin
        w15 = win_reg[1];
        w2  = win_reg[14];
        sched_w = win_reg[0]
                + (sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3))
                + win_reg[9]
                + (sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10));
        rnd_w = (round_reg < 6'd16) ? win_reg[0] : sched_w;
        s1 = sha_pkg::rotr(vars_reg[4], 6) ^ sha_pkg::rotr(vars_reg[4], 11)
           ^ sha_pkg::rotr(vars_reg[4], 25);
        ch = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        t1 = vars_reg[7] + s1 + ch + sha_pkg::RoundK[round_reg] + rnd_w;
        s0 = sha_pkg::rotr(vars_reg[0], 2) ^ sha_pkg::rotr(vars_reg[0], 13)
           ^ sha_pkg::rotr(vars_reg[0], 22);
        mj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
           ^ (vars_reg[1] & vars_reg[2]);
        t2 = s0 + mj;
    end

    // Window: byte writes while filling; shifts one word per round, taking back
    // the block word for the first 16 rounds and a new schedule word after. Cleared on fold or restart.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) win_reg[i] <= '0;
        end
        else if (cmd.absorb || cmd.pad_byte)
        begin
            win_reg[put_w][(3 - put_b) * 8 +: 8] <= put_val;
        end
        else if (cmd.put_length)
        begin
            win_reg[14] <= count_reg[63:32];
            win_reg[15] <= count_reg[31:0];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++) win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= rnd_w;
        end
        else if (cmd.fold || cmd.restart)
        begin
            for (int i = 0; i < 16; i++) win_reg[i] <= '0;
        end
    end

    // Working variables.
    always_ff @(posedge clk)
    begin
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++) vars_reg[i] <= hash_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 1; i < 8; i++)
                if (i != 4) vars_reg[i] <= vars_reg[i - 1];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[0] <= t1 + t2;
        end
    end

    // Chain hash, slot, round counter and bit count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= sha_pkg::iv_word(3'(i));
            count_reg <= '0;
            slot_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.absorb)
                count_reg <= count_reg + 64'd8;
            if (cmd.absorb || cmd.pad_byte)
                slot_reg <= slot_reg + 6'd1;
            if (cmd.round)
                round_reg <= round_reg + 6'd1;
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + vars_reg[i];
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < 7; i++) hash_reg[i] <= hash_reg[i + 1];
                hash_reg[7] <= hash_reg[0];
            end
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= sha_pkg::iv_word(3'(i));
                count_reg <= '0;
                slot_reg  <= '0;
            end
        end
    end

    assign stat.byte_slot   = slot_reg;
    assign stat.round_count = round_reg;
    assign head_word        = hash_reg[0];

endmodule

FILE: src/sha_control.sv
// Controller of the SHA-256 engine: sequences intake, padding, rounds
// and digest output. Depends on sha_pkg.
module sha_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    input  sha_pkg::sha_stat_t  stat,
    output sha_pkg::sha_cmd_t   cmd
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StLoad  = 3'd1;
    localparam logic [2:0] StRound = 3'd2;
    localparam logic [2:0] StFold  = 3'd3;
    localparam logic [2:0] StPad   = 3'd4;
    localparam logic [2:0] StLen   = 3'd5;
    localparam logic [2:0] StOut   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       closing_reg, closing_next;  // message is being closed
    logic       final_reg, final_next;      // block in work is the last one
    logic       first_reg, first_next;      // next pad byte is 0x80
    logic [2:0] word_reg, word_next;
    logic       take;

    assign in_ready  = (state_reg == StIdle);
    assign take      = in_valid && in_ready;
    assign out_valid = (state_reg == StOut);
    assign out_last  = (word_reg == 3'd7);

    always_comb
    begin
        state_next   = state_reg;
        closing_next = closing_reg;
        final_next   = final_reg;
        first_next   = first_reg;
        word_next    = word_reg;
        cmd          = '0;
        case (state_reg)
            StIdle:
            begin
                if (take)
                begin
                    cmd.absorb   = byte_present;
                    closing_next = end_of_message;
                    first_next   = 1'b1;
                    final_next   = 1'b0;
                    if (byte_present && stat.byte_slot == 6'd63)
                        state_next = StLoad;
                    else if (end_of_message)
                        state_next = StPad;
                end
            end
            StPad:
            begin
                // Pad bytes up to the length field or to the end of the block.
                if (!first_reg && stat.byte_slot == 6'd56)
                begin
                    state_next = StLen;
                end
                else
                begin
                    cmd.pad_byte  = 1'b1;
                    cmd.pad_first = first_reg;
                    first_next    = 1'b0;
                    if (stat.byte_slot == 6'd63)
                        state_next = StLoad;
                end
            end
            StLen:
            begin
                cmd.put_length = 1'b1;
                final_next     = 1'b1;
                state_next     = StLoad;
            end
            StLoad:
            begin
                cmd.load_vars = 1'b1;
                state_next    = StRound;
            end
            StRound:
            begin
                cmd.round = 1'b1;
                if (stat.round_count == 6'd63)
                    state_next = StFold;
            end
            StFold:
            begin
                cmd.fold = 1'b1;
                if (final_reg)
                begin
                    word_next  = '0;
                    state_next = StOut;
                end
                else if (closing_reg)
                    state_next = StPad;
                else
                    state_next = StIdle;
            end
            StOut:
            begin
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    word_next     = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        cmd.restart  = 1'b1;
                        closing_next = 1'b0;
                        final_next   = 1'b0;
                        state_next   = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= StIdle;
            closing_reg <= 1'b0;
            final_reg   <= 1'b0;
            first_reg   <= 1'b0;
            word_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            final_reg   <= final_next;
            first_reg   <= first_next;
            word_reg    <= word_next;
        end
    end

endmodule

FILE: src/sha256_hash_engine.sv
// SHA-256 hasher taking one message byte per item. A byte is written into the
// block as it is taken; every 64th byte starts a compression (load, 64 rounds
// through a single round unit, fold). Closing a message pads one byte per
// cycle, runs one or two final compressions and then offers the eight digest
// words, H0 first, with the last one flagged. No item is taken while a message
// is padded, a block compresses or a digest is being delivered.
module sha256_hash_engine (
    input logic clk,
    input logic rst_n,
    sha_if.sink   in_ch,
    sha_if.source out_ch
);

    sha_pkg::sha_cmd_t  cmd;
    sha_pkg::sha_stat_t stat;

    sha_control u_control (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .byte_present   (in_ch.payload.byte_present),
        .end_of_message (in_ch.payload.end_of_message),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_last       (out_ch.payload.last_word),
        .stat           (stat),
        .cmd            (cmd)
    );

    sha_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_byte (in_ch.payload.message_byte),
        .stat         (stat),
        .head_word    (out_ch.payload.digest_word)
    );

endmodule

FILE: tb/sv/sha_tb_pkg.sv
`timescale 1ns / 1ps
// Item types carried on the input and output channels of the SHA-256 engine.
// Depends on nothing; used by tb_top.
package sha_tb_pkg;

    // One message byte, or an empty item, with an optional close flag.
    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } byte_item_t;

    // One digest word, flagged on the eighth.
    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } digest_item_t;

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sha256_hash_engine: streams messages byte by byte,
// predicts each digest with a local SHA-256 model and checks every word.
// Depends on sha_pkg, sha_if, sha_tb_pkg and the engine itself.
module tb_top;

    localparam int CycleLimit = 600000;

    logic clk;
    logic rst_n;

    sha_if #(.payload_t(sha_tb_pkg::byte_item_t))   in_ch ();
    sha_if #(.payload_t(sha_tb_pkg::digest_item_t)) out_ch ();

    sha256_hash_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state: chaining hash, block being filled, bit count, slot.
    sha_pkg::word_t           chain_st [8];
    sha_pkg::word_t           block_w [16];
    logic [63:0]              bit_total;
    int                       fill_slot;
    sha_tb_pkg::digest_item_t digest_q [$];

    int  mismatches;
    int  cycle_cnt;
    bit  no_idle;
    bit  failed;

    localparam sha_pkg::word_t StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic sha_pkg::word_t ror(input sha_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++) chain_st[i] = StartHash[i];
        for (int i = 0; i < 16; i++) block_w[i] = '0;
        bit_total = '0;
        fill_slot = 0;
    endfunction

    function automatic void place_byte(input int s, input logic [7:0] b);
        block_w[s >> 2][(3 - (s & 3)) * 8 +: 8] = b;
    endfunction

    // Run the 64 rounds over the block and fold into the chaining hash.
    function automatic void compress_block();
        sha_pkg::word_t v [8];
        sha_pkg::word_t w, g0, g1, t1, t2, ch, mj, s0, s1;
        int t;
        for (int i = 0; i < 8; i++) v[i] = chain_st[i];
        for (int r = 0; r < 64; r++)
        begin
            t = r & 15;
            if (r < 16)
                w = block_w[t];
            else
            begin
                g0 = ror(block_w[(t + 1) & 15], 7) ^ ror(block_w[(t + 1) & 15], 18)
                     ^ (block_w[(t + 1) & 15] >> 3);
                g1 = ror(block_w[(t + 14) & 15], 17) ^ ror(block_w[(t + 14) & 15], 19)
                     ^ (block_w[(t + 14) & 15] >> 10);
                w = block_w[t] + g0 + block_w[(t + 9) & 15] + g1;
                block_w[t] = w;
            end
            s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + sha_pkg::RoundK[r] + w;
            s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            for (int i = 7; i > 0; i--) v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_st[i] = chain_st[i] + v[i];
        for (int i = 0; i < 16; i++) block_w[i] = '0;
    endfunction

    // Absorb one accepted item; on close, pad and queue the eight digest words.
    function automatic void absorb_item(input sha_tb_pkg::byte_item_t it);
        sha_tb_pkg::digest_item_t d;
        if (it.byte_present)
        begin
            place_byte(fill_slot, it.message_byte);
            bit_total = bit_total + 64'd8;
            fill_slot = (fill_slot + 1) & 63;
            if (fill_slot == 0) compress_block();
        end
        if (!it.end_of_message) return;
        place_byte(fill_slot, 8'h80);
        fill_slot++;
        if (fill_slot > 56)
        begin
            compress_block();
            fill_slot = 0;
        end
        block_w[14] = bit_total[63:32];
        block_w[15] = bit_total[31:0];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = chain_st[i];
            d.last_word   = (i == 7);
            digest_q = {digest_q, d};
        end
        hash_restart();
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always #6 clk = ~clk;

    // Sink side stalls at random.
    always @(negedge clk)
        out_ch.ready <= (pick_gap() == 0);

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit)
        begin
            $display("[sha256_hash_engine] ERROR");
            $finish;
        end
    end

    // Compare each delivered digest word with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_q.size() == 0)
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h last %b",
                             out_ch.payload.digest_word, out_ch.payload.last_word);
            end
            else if (out_ch.payload !== digest_q[0])
            begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: expected %h/%b, got %h/%b",
                             digest_q[0].digest_word, digest_q[0].last_word,
                             out_ch.payload.digest_word, out_ch.payload.last_word);
                void'(digest_q.pop_front());
            end
            else
                void'(digest_q.pop_front());
        end
    end

    // Offer one item from a falling edge and hold it until accepted.
    task automatic send_item(input logic [7:0] b, input bit present, input bit close);
        sha_tb_pkg::byte_item_t it;
        int gap;
        it.message_byte   = b;
        it.byte_present   = present;
        it.end_of_message = close;
        gap = pick_gap();
        repeat (gap) @(negedge clk);
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        do @(posedge clk); while (!in_ch.ready);
        absorb_item(it);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Send a message of random bytes, closed on the last byte or by an empty item.
    task automatic send_message(input int len, input bit noise);
        bit close_on_data;
        close_on_data = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            if (noise && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, close_on_data && (i == len - 1));
        end
        if (!close_on_data) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Empty message, short text, byte extremes and an empty non-closing item.
    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
    endtask

    // Padding that spills into a second block and a full block, idling off.
    task automatic test_padding_edges();
        int lens [2] = '{56, 64};
        no_idle = 1;
        foreach (lens[i]) send_message(lens[i], 1'b0);
        no_idle = 0;
    endtask

    // Random short messages with scattered empty items.
    task automatic test_random_messages();
        int items;
        int len;
        items = 0;
        while (items < 25)
        begin
            len = $urandom_range(0, 12);
            no_idle = ($urandom_range(0, 4) == 0);
            send_message(len, 1'b1);
            items += len + 1;
        end
        no_idle = 0;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        cycle_cnt     = 0;
        mismatches    = 0;
        failed        = 0;
        no_idle       = 0;
        hash_restart();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_padding_edges();
        test_random_messages();

        while (digest_q.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (!failed && digest_q.size() == 0)
            $display("[sha256_hash_engine] OK");
        else
            $display("[sha256_hash_engine] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/sha_pkg.sv
src/sha_if.sv
src/sha_datapath.sv
src/sha_control.sv
src/sha256_hash_engine.sv
tb/sv/sha_tb_pkg.sv
tb/sv/tb_top.sv
